/* rtl/core/joint_histogram_accumulate_macros.svh */
// ----------------------------------------------------------------------------
// Joint histogram accumulate assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef JOINT_HISTOGRAM_ACCUMULATE_MACROS_SVH
`define JOINT_HISTOGRAM_ACCUMULATE_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define JHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define JHA_ASSERT_NEXT(label, clk, ante, cons, rst_n, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define JHA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/jha_pkg.sv */
// ----------------------------------------------------------------------------
// Joint histogram accumulate package
// Widths, bus layouts and codes shared by the histogram core and its checker.
// ----------------------------------------------------------------------------
package jha_pkg;

    localparam int MAX_BINS_X = 64;
    localparam int MAX_BINS_Y = 64;

    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 32;
    localparam int BINS_W    = 7;
    localparam int BIN_COL_W = $clog2(MAX_BINS_X);
    localparam int BIN_ROW_W = $clog2(MAX_BINS_Y);
    localparam int ADDR_W    = BIN_ROW_W + BIN_COL_W;
    localparam int DEPTH     = MAX_BINS_X * MAX_BINS_Y;
    localparam int NUM_W     = BINS_W + SAMPLE_W;
    localparam int STEP_W    = $clog2(BINS_W);

    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Input tdata: sample_x, sample_y, weight, read_col, read_row, pad.
    localparam int IN_FIELDS_W = 3 * SAMPLE_W + BIN_COL_W + BIN_ROW_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output tdata: bin_col, bin_row, bin_count, total_count, pad.
    localparam int OUT_FIELDS_W = BIN_COL_W + BIN_ROW_W + 2 * COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [SAMPLE_W-1:0] LOW_RESET  = '0;
    localparam logic [SAMPLE_W-1:0] HIGH_RESET = '1;
    localparam logic [BINS_W-1:0]   BINS_X_RESET = BINS_W'(MAX_BINS_X);
    localparam logic [BINS_W-1:0]   BINS_Y_RESET = BINS_W'(MAX_BINS_Y);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LOW  = 3'd0,
        CFG_X_HIGH = 3'd1,
        CFG_Y_LOW  = 3'd2,
        CFG_Y_HIGH = 3'd3,
        CFG_BINS_X = 3'd4,
        CFG_BINS_Y = 3'd5
    } t_cfg_idx;

endpackage

/* rtl/core/jha_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module jha_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/joint_histogram_accumulate.sv */
// Sequence: add/remove goes through S_MUL, the 7-step bin divider, S_RD and S_UPD; a read skips
//   the divider, and a rejected or unused word goes from S_MUL straight to S_UPD. One word is in
//   flight at a time; the divider is one per axis, with a shared step count. A finished result
//   waits in the output register while the next word is taken.
// Reset (i_rst_n low, synchronous): clears total and output valid, sets the configuration defaults,
//   then a clearing pass zeroes all 4096 bins, one a cycle, during which o_s_tready stays low.
// ----------------------------------------------------------------------------
// Joint histogram accumulate
// Two-dimensional weighted histogram kept in a bin RAM, updated by
// read-modify-write, with a bin-index divider per axis.
// ----------------------------------------------------------------------------
module joint_histogram_accumulate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [15:0] sample_x, [31:16] sample_y, [47:32] weight, [53:48] read_col,
    // [59:54] read_row, [63:60] zero
    input  logic [jha_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // [1:0] cmd
    input  logic [jha_pkg::CMD_W-1:0]         i_s_tuser,
    // Output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [5:0] bin_col, [11:6] bin_row, [43:12] bin_count, [75:44] total_count,
    // [79:76] zero
    output logic [jha_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // [0] accepted
    output logic                              o_m_tuser,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [jha_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [jha_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import jha_pkg::*;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_RD    = 6'b010000,
        S_UPD   = 6'b100000
    } t_state;

    // What the final step does with the item.
    typedef enum logic [1:0] {
        KIND_REJECT = 2'd0,
        KIND_READ   = 2'd1,
        KIND_UPDATE = 2'd2
    } t_kind;

    t_state r_state, n_state;
    t_kind  r_kind;

    // Configuration registers.
    logic [SAMPLE_W-1:0] r_x_low, r_x_high, r_y_low, r_y_high;
    logic [BINS_W-1:0]   r_bins_x, r_bins_y;

    // Latched item.
    t_cmd                 r_cmd;
    logic [SAMPLE_W-1:0]  r_sx, r_sy, r_w;
    logic [BIN_COL_W-1:0] r_rc;
    logic [BIN_ROW_W-1:0] r_rr;

    // Divider state: remainder, divisor, quotient per axis, shared step count.
    logic [NUM_W-1:0]    r_num_x, r_num_y;
    logic [SAMPLE_W-1:0] r_div_x, r_div_y;
    logic [BINS_W-1:0]   r_q_x, r_q_y;
    logic [BINS_W-1:0]   r_nbx, r_nby;
    logic [STEP_W-1:0]   r_step;

    logic [BIN_COL_W-1:0] r_col;
    logic [BIN_ROW_W-1:0] r_row;
    logic [COUNT_W-1:0]   r_total;
    logic [ADDR_W-1:0]    r_clr_addr;

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_acc;
    logic [BIN_COL_W-1:0] r_out_col;
    logic [BIN_ROW_W-1:0] r_out_row;
    logic [COUNT_W-1:0]   r_out_cnt;
    logic [COUNT_W-1:0]   r_out_total;

    // Combinational helpers.
    logic                 s_acc, out_free;
    logic [BINS_W-1:0]    nbx, nby;
    logic                 in_x, in_y;
    logic [SAMPLE_W-1:0]  diff_x, diff_y, span_x, span_y;
    logic [NUM_W-1:0]     trial_x, trial_y;
    logic [BIN_COL_W-1:0] col_sel;
    logic [BIN_ROW_W-1:0] row_sel;
    logic [BINS_W-1:0]    col_clamp, row_clamp;
    logic [COUNT_W-1:0]   w_ext, rdata, new_cnt, new_total;
    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [COUNT_W-1:0]   ram_wdata;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    // Effective bin counts: zero acts as one, above the store size acts as the maximum.
    always_comb begin
        priority if (r_bins_x == '0)                   nbx = BINS_W'(1);
        else if (r_bins_x > BINS_W'(MAX_BINS_X))        nbx = BINS_W'(MAX_BINS_X);
        else                                            nbx = r_bins_x;
        priority if (r_bins_y == '0)                   nby = BINS_W'(1);
        else if (r_bins_y > BINS_W'(MAX_BINS_Y))        nby = BINS_W'(MAX_BINS_Y);
        else                                            nby = r_bins_y;
    end

    // Range check and offsets; an empty span divides by one to give bin 0.
    assign in_x   = (r_sx >= r_x_low) && (r_sx <= r_x_high);
    assign in_y   = (r_sy >= r_y_low) && (r_sy <= r_y_high);
    assign diff_x = r_sx - r_x_low;
    assign diff_y = r_sy - r_y_low;
    assign span_x = r_x_high - r_x_low;
    assign span_y = r_y_high - r_y_low;

    // Restoring division, one quotient bit per cycle from the top.
    assign trial_x = NUM_W'(r_div_x) << r_step;
    assign trial_y = NUM_W'(r_div_y) << r_step;

    // Clamp the quotient (equal to bins when v is at the high end).
    assign col_clamp = (r_q_x >= r_nbx) ? r_nbx - BINS_W'(1) : r_q_x;
    assign row_clamp = (r_q_y >= r_nby) ? r_nby - BINS_W'(1) : r_q_y;
    assign col_sel   = (r_kind == KIND_READ) ? r_rc : col_clamp[BIN_COL_W-1:0];
    assign row_sel   = (r_kind == KIND_READ) ? r_rr : row_clamp[BIN_ROW_W-1:0];

    // Modify step on the word read back from the bin RAM.
    assign w_ext = COUNT_W'(r_w);
    always_comb begin
        if (r_cmd == CMD_REMOVE) begin
            new_cnt   = rdata - w_ext;
            new_total = r_total - w_ext;
        end else begin
            new_cnt   = rdata + w_ext;
            new_total = r_total + w_ext;
        end
    end

    // RAM control: clearing pass, else write-back of the updated bin.
    // Reads happen only in S_RD and write-back only in S_UPD, which follows it, so no overlap.
    always_comb begin
        ram_re = (r_state == S_RD);
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_UPD) && out_free && (r_kind == KIND_UPDATE);
            ram_waddr = {r_row, r_col};
            ram_wdata = new_cnt;
        end
    end

    jha_ram #(
        .DATA_W (COUNT_W),
        .DEPTH  (DEPTH)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr ({row_sel, col_sel}),
        .o_rdata (rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_acc) n_state = S_MUL;
            end
            S_MUL: begin
                priority if (r_cmd == CMD_READ)                  n_state = S_RD;
                else if ((r_cmd == CMD_ADD || r_cmd == CMD_REMOVE) && in_x && in_y)
                                                                 n_state = S_DIV;
                else                                             n_state = S_UPD;
            end
            S_DIV: begin
                if (r_step == '0) n_state = S_RD;
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_x_low     <= LOW_RESET;
            r_x_high    <= HIGH_RESET;
            r_y_low     <= LOW_RESET;
            r_y_high    <= HIGH_RESET;
            r_bins_x    <= BINS_X_RESET;
            r_bins_y    <= BINS_Y_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            // Register writes; indexes past the list are dropped.
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_X_LOW:  r_x_low  <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_X_HIGH: r_x_high <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_Y_LOW:  r_y_low  <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_Y_HIGH: r_y_high <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_BINS_X: r_bins_x <= i_cfg_data[BINS_W-1:0];
                    CFG_BINS_Y: r_bins_y <= i_cfg_data[BINS_W-1:0];
                    default: ;
                endcase
            end
            // Hold the result until taken; load a new one when the slot frees.
            if (r_state == S_UPD && out_free) begin
                r_out_valid <= 1'b1;
                if (r_kind == KIND_UPDATE) r_total <= new_total;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_sx  <= i_s_tdata[SAMPLE_W-1:0];
                    r_sy  <= i_s_tdata[2*SAMPLE_W-1:SAMPLE_W];
                    r_w   <= i_s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
                    r_rc  <= i_s_tdata[3*SAMPLE_W+BIN_COL_W-1:3*SAMPLE_W];
                    r_rr  <= i_s_tdata[IN_FIELDS_W-1:3*SAMPLE_W+BIN_COL_W];
                    r_cmd <= t_cmd'(i_s_tuser);
                end
            end
            S_MUL: begin
                r_num_x <= NUM_W'(nbx) * NUM_W'(diff_x);
                r_num_y <= NUM_W'(nby) * NUM_W'(diff_y);
                r_div_x <= (span_x == '0) ? SAMPLE_W'(1) : span_x;
                r_div_y <= (span_y == '0) ? SAMPLE_W'(1) : span_y;
                r_nbx   <= nbx;
                r_nby   <= nby;
                r_q_x   <= '0;
                r_q_y   <= '0;
                r_step  <= STEP_W'(BINS_W - 1);
                priority if (r_cmd == CMD_READ)                  r_kind <= KIND_READ;
                else if ((r_cmd == CMD_ADD || r_cmd == CMD_REMOVE) && in_x && in_y)
                                                                 r_kind <= KIND_UPDATE;
                else                                             r_kind <= KIND_REJECT;
            end
            S_DIV: begin
                if (r_num_x >= trial_x) begin
                    r_num_x        <= r_num_x - trial_x;
                    r_q_x[r_step]  <= 1'b1;
                end
                if (r_num_y >= trial_y) begin
                    r_num_y        <= r_num_y - trial_y;
                    r_q_y[r_step]  <= 1'b1;
                end
                r_step <= r_step - STEP_W'(1);
            end
            S_RD: begin
                r_col <= col_sel;
                r_row <= row_sel;
            end
            S_UPD: begin
                if (out_free) begin
                    unique case (r_kind)
                        KIND_UPDATE: begin
                            r_out_acc   <= 1'b1;
                            r_out_col   <= r_col;
                            r_out_row   <= r_row;
                            r_out_cnt   <= new_cnt;
                            r_out_total <= new_total;
                        end
                        KIND_READ: begin
                            r_out_acc   <= 1'b0;
                            r_out_col   <= r_col;
                            r_out_row   <= r_row;
                            r_out_cnt   <= rdata;
                            r_out_total <= r_total;
                        end
                        default: begin
                            r_out_acc   <= 1'b0;
                            r_out_col   <= '0;
                            r_out_row   <= '0;
                            r_out_cnt   <= '0;
                            r_out_total <= r_total;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_acc;
    assign o_m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), r_out_total, r_out_cnt,
                         r_out_row, r_out_col};

endmodule

/* rtl/core/jha_checker.sv */
// ----------------------------------------------------------------------------
// Joint histogram accumulate checker
// Port-level assertions on the histogram core, bound to the top level.
// ----------------------------------------------------------------------------
`include "joint_histogram_accumulate_macros.svh"

module jha_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [jha_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input logic                              o_m_tuser
);
    import jha_pkg::*;

    // Reset starts the clearing pass: no input word taken, no result pending.
    `JHA_ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !o_s_tready && !o_m_tvalid, "input open or result pending right after reset")

    // One word at a time: the cycle after a word is taken, the input is closed.
    `JHA_ASSERT_NEXT(a_one_in_flight, i_clk, i_s_tvalid && o_s_tready, !o_s_tready, i_rst_n, "input taken twice in a row")

    // A stalled result word stays put.
    `JHA_ASSERT_NEXT(a_out_hold, i_clk, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), i_rst_n, "stalled result word changed")

endmodule

bind joint_histogram_accumulate jha_checker u_jha_checker (.*);
